// ===== design/pbcgt_pkg.sv =====
// Shared types and constants for the pixel brightness, contrast, gray and threshold pipeline.
package pbcgt_pkg;

	localparam int PixW     = 8;
	localparam int BrightW  = 9;
	localparam int ContW    = 9;
	localparam int CfgDataW = 9;
	localparam int CfgIdxW  = 3;

	// Reset values of the configuration registers.
	localparam logic signed [BrightW-1:0] BrightReset = 9'sd0;
	localparam logic [ContW-1:0]          ContReset   = 9'd100;
	localparam logic [PixW-1:0]           ThrReset    = 8'd127;

	// Contrast midpoint.
	localparam int Mid = 127;

	// Reciprocal for an exact floor division by 25 of a 14-bit value (shift 19).
	localparam int RecipContW     = 15;
	localparam int RecipCont      = 20972;
	localparam int RecipContShift = 19;

	// Reciprocal for an exact floor division by 125 of a 15-bit value (shift 22).
	localparam int RecipLumaW     = 16;
	localparam int RecipLuma      = 33555;
	localparam int RecipLumaShift = 22;

	// Luma weights in thousandths, plus the rounding term.
	localparam int WeightR   = 299;
	localparam int WeightG   = 587;
	localparam int WeightB   = 114;
	localparam int LumaRound = 500;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BRIGHTNESS = 3'd0,
		REG_CONTRAST   = 3'd1,
		REG_THRESHOLD  = 3'd2,
		REG_SRC_GRAY   = 3'd3,
		REG_GRAY_EN    = 3'd4,
		REG_THR_EN     = 3'd5
	} reg_idx_t;

	// Configuration seen by the gray and threshold stages.
	typedef struct packed {
		logic            gray_en;
		logic            thr_en;
		logic            src_gray;
		logic [PixW-1:0] thr_level;
	} luma_cfg_t;

	// Load strobes, one for each pipeline stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_ld_t;

endpackage

// ===== design/pbcgt_chan.sv =====
// Brightness and contrast datapath for one colour channel, stages one to four.
module pbcgt_chan (
	input  logic                                      clk,
	input  pbcgt_pkg::stage_ld_t                      ld,
	input  logic signed [pbcgt_pkg::BrightW-1:0]      brightness,
	input  logic [pbcgt_pkg::ContW-1:0]               contrast,
	input  logic [pbcgt_pkg::PixW-1:0]                pix,
	output logic [pbcgt_pkg::PixW-1:0]                chan_s4
);

	localparam int QProdW = 14 + pbcgt_pkg::RecipContW;

	logic signed [9:0]  sum_bright;
	logic [7:0]         bright_s1;
	logic signed [9:0]  diff;
	logic signed [19:0] prod;
	logic signed [19:0] prod_s2;
	logic signed [20:0] num;
	logic [19:0]        mag;
	logic [QProdW-1:0]  qprod;
	logic [QProdW-1:0]  qprod_s3;
	logic               neg_s3;
	logic [9:0]         quot;
	logic signed [11:0] res;

	// Stage one: add the offset and clamp to a byte.
	assign sum_bright = $signed({2'b00, pix}) + 10'(brightness);

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			if (sum_bright[9])
				bright_s1 <= 8'd0;
			else if (sum_bright[8])
				bright_s1 <= 8'd255;
			else
				bright_s1 <= sum_bright[7:0];
		end
	end

	// Stage two: distance from the midpoint times the gain.
	assign diff = $signed({2'b00, bright_s1}) - 10'(pbcgt_pkg::Mid);
	assign prod = diff * $signed({1'b0, contrast});

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			prod_s2 <= prod;
		end
	end

	// Stage three: magnitude of the rounded numerator, divided by 8 and then by 25
	// through a reciprocal product. The sign is kept for truncation toward zero.
	assign num   = (21'(prod_s2) <<< 1) + 21'sd100;
	assign mag   = num[20] ? 20'(-num) : 20'(num);
	assign qprod = QProdW'(mag[16:3]) * QProdW'(pbcgt_pkg::RecipCont);

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			qprod_s3 <= qprod;
			neg_s3   <= num[20];
		end
	end

	// Stage four: restore the sign, add the midpoint and clamp.
	assign quot = qprod_s3[pbcgt_pkg::RecipContShift +: 10];
	assign res  = neg_s3 ? (12'(pbcgt_pkg::Mid) - $signed({2'b00, quot}))
	                     : (12'(pbcgt_pkg::Mid) + $signed({2'b00, quot}));

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			if (res[11])
				chan_s4 <= 8'd0;
			else if (res > 12'sd255)
				chan_s4 <= 8'd255;
			else
				chan_s4 <= res[7:0];
		end
	end

endmodule

// ===== design/pbcgt_luma.sv =====
// Gray conversion and binary threshold, stages five to seven.
module pbcgt_luma (
	input  logic                          clk,
	input  pbcgt_pkg::stage_ld_t          ld,
	input  pbcgt_pkg::luma_cfg_t          cfg,
	input  logic [pbcgt_pkg::PixW-1:0]    red_s4,
	input  logic [pbcgt_pkg::PixW-1:0]    green_s4,
	input  logic [pbcgt_pkg::PixW-1:0]    blue_s4,
	output logic [pbcgt_pkg::PixW-1:0]    red_s7,
	output logic [pbcgt_pkg::PixW-1:0]    green_s7,
	output logic [pbcgt_pkg::PixW-1:0]    blue_s7
);

	localparam int SumW  = 18;
	localparam int LProdW = 31;

	logic [SumW-1:0]    wsum;
	logic [SumW-1:0]    wsum_s5;
	logic [7:0]         red_s5, green_s5, blue_s5;
	logic [LProdW-1:0]  lprod;
	logic [LProdW-1:0]  lprod_s6;
	logic [7:0]         red_s6, green_s6, blue_s6;
	logic [7:0]         gray;
	logic [7:0]         r_sel, g_sel, b_sel;
	logic               thr_on;
	logic [7:0]         thr_val;

	// Stage five: weighted sum with rounding.
	assign wsum = SumW'(red_s4) * SumW'(pbcgt_pkg::WeightR)
	            + SumW'(green_s4) * SumW'(pbcgt_pkg::WeightG)
	            + SumW'(blue_s4) * SumW'(pbcgt_pkg::WeightB)
	            + SumW'(pbcgt_pkg::LumaRound);

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			wsum_s5  <= wsum;
			red_s5   <= red_s4;
			green_s5 <= green_s4;
			blue_s5  <= blue_s4;
		end
	end

	// Stage six: divide by 8 by shifting, then by 125 through a reciprocal product.
	assign lprod = LProdW'(wsum_s5[SumW-1:3]) * LProdW'(pbcgt_pkg::RecipLuma);

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			lprod_s6 <= lprod;
			red_s6   <= red_s5;
			green_s6 <= green_s5;
			blue_s6  <= blue_s5;
		end
	end

	// Stage seven: choose gray or colour, then threshold on the red channel.
	assign gray    = lprod_s6[pbcgt_pkg::RecipLumaShift +: 8];
	assign r_sel   = cfg.gray_en ? gray : red_s6;
	assign g_sel   = cfg.gray_en ? gray : green_s6;
	assign b_sel   = cfg.gray_en ? gray : blue_s6;
	assign thr_on  = cfg.thr_en & (cfg.src_gray | cfg.gray_en);
	assign thr_val = (r_sel >= cfg.thr_level) ? 8'd255 : 8'd0;

	always_ff @(posedge clk) begin
		if (ld.s7) begin
			red_s7   <= thr_on ? thr_val : r_sel;
			green_s7 <= thr_on ? thr_val : g_sel;
			blue_s7  <= thr_on ? thr_val : b_sel;
		end
	end

endmodule

// ===== design/pixel_brightness_contrast_gray_threshold_unit.sv =====
// Top level of the pixel brightness, contrast, gray and threshold pipeline.
//
//   Channel   Signals                                Direction  Moves
//   in        in_valid, in_stall, red/green/blue_in  sink       one pixel request
//   out       out_valid, out_stall, red/green/blue_out source   one processed pixel
//   config    wr_en, wr_index, wr_data               sink       one register write
//
// A pixel's result passes through the seven register stages of the datapath, the last of
// which is the output register, and a new pixel can be accepted in every cycle in which
// in_stall is low.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds its request while the stage after it is full and cannot move, so a
// stall on the output fills the bubbles first and reaches in_stall only when all seven
// stages hold a pixel. Nothing is dropped or repeated under a stall.
module pixel_brightness_contrast_gray_threshold_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pbcgt_pkg::PixW-1:0]         red_in,
	input  logic [pbcgt_pkg::PixW-1:0]         green_in,
	input  logic [pbcgt_pkg::PixW-1:0]         blue_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pbcgt_pkg::PixW-1:0]         red_out,
	output logic [pbcgt_pkg::PixW-1:0]         green_out,
	output logic [pbcgt_pkg::PixW-1:0]         blue_out,
	input  logic                               wr_en,
	input  logic [pbcgt_pkg::CfgIdxW-1:0]      wr_index,
	input  logic [pbcgt_pkg::CfgDataW-1:0]     wr_data
);

	// Configuration registers.
	logic signed [pbcgt_pkg::BrightW-1:0] brightness_q;
	logic [pbcgt_pkg::ContW-1:0]          contrast_q;
	logic [pbcgt_pkg::PixW-1:0]           thr_level_q;
	logic                                 src_gray_q;
	logic                                 gray_en_q;
	logic                                 thr_en_q;

	// Stage valid bits and the ready chain that runs back from the output.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	pbcgt_pkg::stage_ld_t ld;
	pbcgt_pkg::luma_cfg_t luma_cfg;

	logic [pbcgt_pkg::PixW-1:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= pbcgt_pkg::BrightReset;
			contrast_q   <= pbcgt_pkg::ContReset;
			thr_level_q  <= pbcgt_pkg::ThrReset;
			src_gray_q   <= 1'b0;
			gray_en_q    <= 1'b0;
			thr_en_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				pbcgt_pkg::REG_BRIGHTNESS: brightness_q <= $signed(wr_data[8:0]);
				pbcgt_pkg::REG_CONTRAST:   contrast_q   <= wr_data[8:0];
				pbcgt_pkg::REG_THRESHOLD:  thr_level_q  <= wr_data[7:0];
				pbcgt_pkg::REG_SRC_GRAY:   src_gray_q   <= wr_data[0];
				pbcgt_pkg::REG_GRAY_EN:    gray_en_q    <= wr_data[0];
				pbcgt_pkg::REG_THR_EN:     thr_en_q     <= wr_data[0];
				default: begin
					// Writes to unused indexes are ignored.
				end
			endcase
		end
	end

	// A stage can take new data when it is empty or when its own content moves on.
	assign rdy7 = ~v_s7 | ~out_stall;
	assign rdy6 = ~v_s6 | rdy7;
	assign rdy5 = ~v_s5 | rdy6;
	assign rdy4 = ~v_s4 | rdy5;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;

	assign in_stall = ~rdy1;

	// Data registers load only when a valid request moves into them.
	assign ld.s1 = rdy1 & in_valid;
	assign ld.s2 = rdy2 & v_s1;
	assign ld.s3 = rdy3 & v_s2;
	assign ld.s4 = rdy4 & v_s3;
	assign ld.s5 = rdy5 & v_s4;
	assign ld.s6 = rdy6 & v_s5;
	assign ld.s7 = rdy7 & v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// The three colour channels run through identical brightness and contrast paths.
	pbcgt_chan u_chan_red (
		.clk        (clk),
		.ld         (ld),
		.brightness (brightness_q),
		.contrast   (contrast_q),
		.pix        (red_in),
		.chan_s4    (red_s4)
	);

	pbcgt_chan u_chan_green (
		.clk        (clk),
		.ld         (ld),
		.brightness (brightness_q),
		.contrast   (contrast_q),
		.pix        (green_in),
		.chan_s4    (green_s4)
	);

	pbcgt_chan u_chan_blue (
		.clk        (clk),
		.ld         (ld),
		.brightness (brightness_q),
		.contrast   (contrast_q),
		.pix        (blue_in),
		.chan_s4    (blue_s4)
	);

	assign luma_cfg.gray_en   = gray_en_q;
	assign luma_cfg.thr_en    = thr_en_q;
	assign luma_cfg.src_gray  = src_gray_q;
	assign luma_cfg.thr_level = thr_level_q;

	// Gray conversion and threshold; its last stage is the output register.
	pbcgt_luma u_luma (
		.clk      (clk),
		.ld       (ld),
		.cfg      (luma_cfg),
		.red_s4   (red_s4),
		.green_s4 (green_s4),
		.blue_s4  (blue_s4),
		.red_s7   (red_out),
		.green_s7 (green_out),
		.blue_s7  (blue_out)
	);

	assign out_valid = v_s7;

	// The input may only be held off when every stage is full and the output is stalled.
	a_in_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_valid && out_stall))
		else $error("input stalled while the pipeline still has room");

	// An accepted pixel always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted pixel did not enter the first stage");

	// A middle stage that cannot move keeps its request.
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy5) |=> v_s4)
		else $error("stage four lost a request under a stall");

endmodule
